// ===== design/pipr_pkg.sv =====
// ----------------------------------------------------------------------------
// pipr_pkg
// Shared types and constants for the point-in-polygon ray crossing unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pipr_pkg;

  // fixed field widths of the channels
  localparam int COORD_W = 32;
  localparam int CROSS_W = 16;

  // default parameter values of the top level
  localparam int COORD_BITS_DEF = 32;
  localparam int COUNT_BITS_DEF = 16;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [CROSS_W-1:0]        cross_t;

  // per-item control carried down the pipeline
  typedef struct packed {
    logic start;   // first vertex of a polygon
    logic en_a;    // edge from the previous vertex is tested
    logic last;    // closing edge is tested, result is due
  } item_ctl_t;

  // stage load enables for the edge datapath
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } pipe_ld_t;

endpackage

`default_nettype wire

// ===== design/pipr_if.sv =====
// ----------------------------------------------------------------------------
// pipr_if
// Valid/ready channels: vertex items in, crossing results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface pipr_in_if;
  import pipr_pkg::*;

  logic   valid;
  logic   ready;
  coord_t vertex_x;
  coord_t vertex_y;
  coord_t query_x;
  coord_t query_y;
  logic   last_vertex;

  modport source (
    output valid, vertex_x, vertex_y, query_x, query_y, last_vertex,
    input  ready
  );
  modport sink (
    input  valid, vertex_x, vertex_y, query_x, query_y, last_vertex,
    output ready
  );
endinterface

interface pipr_out_if;
  import pipr_pkg::*;

  logic   valid;
  logic   ready;
  logic   inside_res;
  cross_t crossings;

  modport source (
    output valid, inside_res, crossings,
    input  ready
  );
  modport sink (
    input  valid, inside_res, crossings,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/pipr_edge.sv =====
// ----------------------------------------------------------------------------
// pipr_edge
// Three-stage edge test: differences, cross products with the span check,
// then the sign test of the cross product against the edge direction.
// ----------------------------------------------------------------------------
`default_nettype none

module pipr_edge #(
  parameter int COORD_BITS = pipr_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  pipr_pkg::pipe_ld_t           ld,
  input  logic signed [COORD_BITS-1:0] x0,
  input  logic signed [COORD_BITS-1:0] y0,
  input  logic signed [COORD_BITS-1:0] x1,
  input  logic signed [COORD_BITS-1:0] y1,
  input  logic signed [COORD_BITS-1:0] qx,
  input  logic signed [COORD_BITS-1:0] qy,
  output logic                         hit
);
  import pipr_pkg::*;

  localparam int DW = COORD_BITS + 1;  // difference width
  localparam int PW = 2 * DW;          // product width
  localparam int NW = PW + 1;          // cross product width

  typedef logic signed [DW-1:0] dif_t;
  typedef logic signed [PW-1:0] prd_t;
  typedef logic signed [NW-1:0] crs_t;

  dif_t sy_r, sx_r, cx_r, cy_r, ncy_r;
  prd_t p1_r, p2_r;
  logic rng_r, neg_r, hit_r;
  logic span_ok;
  crs_t num;

  // stage 1: edge and offset vectors
  always_ff @(posedge clk) begin
    if (ld.s1) begin
      sy_r  <= dif_t'(y1) - dif_t'(y0);
      sx_r  <= dif_t'(x1) - dif_t'(x0);
      cx_r  <= dif_t'(x0) - dif_t'(qx);
      cy_r  <= dif_t'(y0) - dif_t'(qy);
      ncy_r <= dif_t'(qy) - dif_t'(y0);
    end
  end

  // hit parameter within [0,1], horizontal edges excluded
  always_comb begin
    if (sy_r == '0) begin
      span_ok = 1'b0;
    end else if (!sy_r[DW-1]) begin
      span_ok = !ncy_r[DW-1] && (ncy_r <= sy_r);
    end else begin
      span_ok = (ncy_r[DW-1] || (ncy_r == '0)) && (ncy_r >= sy_r);
    end
  end

  // stage 2: cross product terms
  always_ff @(posedge clk) begin
    if (ld.s2) begin
      p1_r  <= cx_r * sy_r;
      p2_r  <= sx_r * cy_r;
      rng_r <= span_ok;
      neg_r <= sy_r[DW-1];
    end
  end

  // stage 3: ray distance sign matches the edge direction, or is zero
  assign num = crs_t'(p1_r) - crs_t'(p2_r);

  always_ff @(posedge clk) begin
    if (ld.s3) begin
      hit_r <= rng_r && ((num == '0) || (num[NW-1] == neg_r));
    end
  end

  assign hit = hit_r;

endmodule

`default_nettype wire

// ===== design/pipr_accum.sv =====
// ----------------------------------------------------------------------------
// pipr_accum
// Crossing count and parity per polygon, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pipr_accum #(
  parameter int COUNT_BITS = pipr_pkg::COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  pipr_pkg::item_ctl_t ctl,
  input  logic                hit_a,
  input  logic                hit_b,
  output logic                out_free,
  pipr_out_if.source          out_item
);
  import pipr_pkg::*;

  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt, base_cnt, out_cnt_r;
  logic [COUNT_BITS:0]   sum;
  logic [1:0]            inc;
  logic                  par_r, par_nxt, base_par;
  logic                  out_valid_r, inside_r;

  // next count and parity, restarting on a first vertex
  always_comb begin
    base_cnt = ctl.start ? '0 : cnt_r;
    base_par = ctl.start ? 1'b0 : par_r;
    inc      = {1'b0, hit_a} + {1'b0, hit_b};
    sum      = {1'b0, base_cnt} + (COUNT_BITS+1)'(inc);
    cnt_nxt  = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
    par_nxt  = base_par ^ hit_a ^ hit_b;
  end

  // running state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      par_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        cnt_r <= cnt_nxt;
        par_r <= par_nxt;
      end
      if (fire && ctl.last) begin
        out_valid_r <= 1'b1;
      end else if (out_item.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (fire && ctl.last) begin
      inside_r  <= par_nxt;
      out_cnt_r <= cnt_nxt;
    end
  end

  assign out_free            = !out_valid_r || out_item.ready;
  assign out_item.valid      = out_valid_r;
  assign out_item.inside_res = inside_r;

  // fit the count to the result field
  generate
    if (COUNT_BITS >= CROSS_W) begin : g_cnt_trunc
      assign out_item.crossings = out_cnt_r[CROSS_W-1:0];
    end else begin : g_cnt_ext
      assign out_item.crossings = {{(CROSS_W-COUNT_BITS){1'b0}}, out_cnt_r};
    end
  endgenerate

`ifndef SYNTHESIS
  // a result appears only after a last vertex leaves the pipeline
  a_out_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(fire && ctl.last))
    else $error("result without a last vertex");

  // below saturation the parity equals the count's low bit
  a_parity_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_cnt_r != '1)) |-> (inside_r == out_cnt_r[0]))
    else $error("parity and count disagree");

  // a single-vertex polygon has no crossings
  a_single_vertex: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && ctl.start && ctl.last) |=> (out_valid_r && (out_cnt_r == '0) && !inside_r))
    else $error("single-vertex polygon counted a crossing");
`endif

endmodule

`default_nettype wire

// ===== design/point_in_polygon_ray_crossing_unit.sv =====
// ----------------------------------------------------------------------------
// point_in_polygon_ray_crossing_unit
// Even-odd ray casting: counts edges crossed by a rightward ray from the
// query point, one vertex item per cycle while not stalled, one result per polygon.
// ----------------------------------------------------------------------------
//   channel   dir  handshake     payload
//   in_item   in   valid/ready   vertex_x, vertex_y, query_x, query_y,
//                                last_vertex
//   out_item  out  valid/ready   inside_res, crossings
//
// One vertex item per cycle while not stalled; a result is offered once its last
// vertex has passed the input register, the edge stages and the result register.
// Both edges of a vertex are tested side by side, two cross products each.
// Reset (rst_n low, synchronous) empties the pipeline and starts a polygon.
// A waiting result stalls only a last vertex at the count stage; other
// items keep flowing until the pipeline fills.
// ----------------------------------------------------------------------------
`default_nettype none

module point_in_polygon_ray_crossing_unit #(
  parameter int COORD_BITS = pipr_pkg::COORD_BITS_DEF,
  parameter int COUNT_BITS = pipr_pkg::COUNT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  pipr_in_if.sink    in_item,
  pipr_out_if.source out_item
);
  import pipr_pkg::*;

  localparam int NSTG = 4;

  typedef logic signed [COORD_BITS-1:0] crd_t;

  crd_t vx, vy, qx, qy;
  crd_t first_x_r, first_y_r, prev_x_r, prev_y_r;
  crd_t a_x0_r, a_y0_r, v_x_r, v_y_r, b_x1_r, b_y1_r, q_x_r, q_y_r;
  logic in_poly_r;
  logic in_fire;

  logic      [NSTG-1:0] v_r;
  logic      [NSTG-1:0] rdy;
  item_ctl_t            ctl_r [NSTG];
  item_ctl_t            ctl_in;
  pipe_ld_t             ld;

  logic hit_a, hit_b, out_free, acc_fire;

  // incoming coordinates at the working width
  assign vx = in_item.vertex_x[COORD_BITS-1:0];
  assign vy = in_item.vertex_y[COORD_BITS-1:0];
  assign qx = in_item.query_x[COORD_BITS-1:0];
  assign qy = in_item.query_y[COORD_BITS-1:0];

  // stage ready chain, a last vertex needs room in the result register
  always_comb begin
    rdy[NSTG-1] = !v_r[NSTG-1] || !ctl_r[NSTG-1].last || out_free;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_item.ready = rdy[0];
  assign in_fire       = in_item.valid && rdy[0];
  assign acc_fire      = v_r[NSTG-1] && rdy[NSTG-1];

  assign ctl_in = '{start: !in_poly_r, en_a: in_poly_r, last: in_item.last_vertex};
  assign ld     = '{s1: rdy[1], s2: rdy[2], s3: rdy[3]};

  // polygon tracking: first and previous vertex
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_poly_r <= 1'b0;
      first_x_r <= '0;
      first_y_r <= '0;
      prev_x_r  <= '0;
      prev_y_r  <= '0;
    end else if (in_fire) begin
      if (!in_poly_r) begin
        first_x_r <= vx;
        first_y_r <= vy;
      end
      prev_x_r  <= vx;
      prev_y_r  <= vy;
      in_poly_r <= !in_item.last_vertex;
    end
  end

  // input register: operands of both edges
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      a_x0_r <= prev_x_r;
      a_y0_r <= prev_y_r;
      v_x_r  <= vx;
      v_y_r  <= vy;
      b_x1_r <= in_poly_r ? first_x_r : vx;
      b_y1_r <= in_poly_r ? first_y_r : vy;
      q_x_r  <= qx;
      q_y_r  <= qy;
    end
  end

  // valid bits of the stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_item.valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // control carried alongside the data
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      ctl_r[0] <= ctl_in;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (rdy[k]) begin
        ctl_r[k] <= ctl_r[k-1];
      end
    end
  end

  // edge from the previous vertex to this one
  pipr_edge #(
    .COORD_BITS (COORD_BITS)
  ) u_edge_a (
    .clk (clk),
    .ld  (ld),
    .x0  (a_x0_r),
    .y0  (a_y0_r),
    .x1  (v_x_r),
    .y1  (v_y_r),
    .qx  (q_x_r),
    .qy  (q_y_r),
    .hit (hit_a)
  );

  // closing edge from this vertex back to the first
  pipr_edge #(
    .COORD_BITS (COORD_BITS)
  ) u_edge_b (
    .clk (clk),
    .ld  (ld),
    .x0  (v_x_r),
    .y0  (v_y_r),
    .x1  (b_x1_r),
    .y1  (b_y1_r),
    .qx  (q_x_r),
    .qy  (q_y_r),
    .hit (hit_b)
  );

  // count, parity and result register
  pipr_accum #(
    .COUNT_BITS (COUNT_BITS)
  ) u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (acc_fire),
    .ctl      (ctl_r[NSTG-1]),
    .hit_a    (hit_a && ctl_r[NSTG-1].en_a),
    .hit_b    (hit_b && ctl_r[NSTG-1].last),
    .out_free (out_free),
    .out_item (out_item)
  );

endmodule

`default_nettype wire
